// ===== src/lssfa_pkg.sv =====
// ----------------------------------------------------------------------------
// lssfa_pkg
// Shared constants, codes and types of the led strip stream-fill animator.
// ----------------------------------------------------------------------------
package lssfa_pkg;

  localparam int MAX_LEDS = 64;
  localparam int AW       = $clog2(MAX_LEDS);
  localparam int PW       = AW + 1;
  localparam int CW       = 24;
  localparam int QDEPTH   = 2;
  localparam int QAW      = $clog2(QDEPTH);

  // input commands
  localparam logic [2:0] CMD_RESTART = 3'd0;
  localparam logic [2:0] CMD_TICK    = 3'd1;
  localparam logic [2:0] CMD_READ    = 3'd2;
  localparam logic [2:0] CMD_WPAT    = 3'd3;
  localparam logic [2:0] CMD_WLED    = 3'd4;

  // jobs for the memory side
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_READ = 3'd1;
  localparam logic [2:0] OP_WPAT = 3'd2;
  localparam logic [2:0] OP_WLED = 3'd3;
  localparam logic [2:0] OP_STEP = 3'd4;

  // register indexes
  localparam logic [2:0] REG_STRIP_LENGTH  = 3'd0;
  localparam logic [2:0] REG_STEP_INTERVAL = 3'd1;
  localparam logic [2:0] REG_DIRECTION_UP  = 3'd2;
  localparam logic [2:0] REG_MOVE_PLACED   = 3'd3;
  localparam logic [2:0] REG_MOVE_CURRENT  = 3'd4;

  typedef struct packed {
    logic [6:0]  strip_length;
    logic [15:0] step_interval;
    logic        direction_up;
    logic        move_placed;
    logic        move_current;
  } cfg_t;

  typedef struct packed {
    logic [2:0]    op;
    logic [AW-1:0] addr;
    logic [CW-1:0] color;
    logic [AW-1:0] pos;
    logic [PW-1:0] len;
    logic [PW-1:0] fill_position;
    logic          finished;
  } job_t;

  // strip length clamped to 1..MAX_LEDS
  function automatic logic [PW-1:0] eff_len(input logic [6:0] sl);
    logic [PW-1:0] r;
    if (sl == 7'd0) begin
      r = PW'(1);
    end else if (sl > 7'(MAX_LEDS)) begin
      r = PW'(MAX_LEDS);
    end else begin
      r = PW'(sl);
    end
    return r;
  endfunction

endpackage

// ===== src/lssfa_if.sv =====
// ----------------------------------------------------------------------------
// lssfa channel interfaces
// Input command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lssfa_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [5:0]  led_address;
  logic [23:0] color_value;
  modport source (output valid, command, led_address, color_value, input ready);
  modport sink (input valid, command, led_address, color_value, output ready);
endinterface

interface lssfa_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  fill_position;
  logic        finished;
  logic [23:0] read_color;
  modport source (output valid, fill_position, finished, read_color, input ready);
  modport sink (input valid, fill_position, finished, read_color, output ready);
endinterface

// ===== src/lssfa_front.sv =====
// ----------------------------------------------------------------------------
// lssfa_front
// Takes commands, keeps tick counter and fill position, emits jobs.
// ----------------------------------------------------------------------------
module lssfa_front (
  input  logic               clk,
  input  logic               rst,
  input  lssfa_pkg::cfg_t    cfg,
  lssfa_in_if.sink           in_ch,
  input  logic               q_full,
  output logic               push,
  output lssfa_pkg::job_t    job
);

  logic [15:0]              tick_count;
  logic [15:0]              tick_count_next;
  logic [lssfa_pkg::PW-1:0] position;
  logic [lssfa_pkg::PW-1:0] position_next;
  logic [lssfa_pkg::PW-1:0] len;
  logic [lssfa_pkg::PW-1:0] start;
  logic [lssfa_pkg::PW-1:0] p0;
  logic [lssfa_pkg::PW-1:0] pstep;
  logic                     tick_done;
  logic                     step;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    len   = lssfa_pkg::eff_len(cfg.strip_length);
    start = cfg.direction_up ? '0 : len - lssfa_pkg::PW'(1);
    p0    = (tick_count == 16'd0) ? start : position;
    tick_done = (p0 >= len);
    step      = !tick_done && (tick_count >= cfg.step_interval);
    if (cfg.direction_up) begin
      pstep = p0 + lssfa_pkg::PW'(1);
    end else begin
      pstep = (p0 == '0) ? len : p0 - lssfa_pkg::PW'(1);
    end

    tick_count_next = tick_count;
    position_next   = position;
    job             = '0;
    job.addr        = in_ch.led_address;
    job.color       = in_ch.color_value;
    job.pos         = p0[lssfa_pkg::AW-1:0];
    job.len         = len;
    job.op          = lssfa_pkg::OP_NONE;
    case (in_ch.command)
      lssfa_pkg::CMD_RESTART: begin
        tick_count_next = '0;
        position_next   = start;
      end
      lssfa_pkg::CMD_TICK: begin
        position_next = p0;
        if (tick_done) begin
          job.finished = 1'b1;
        end else if (step) begin
          job.op          = lssfa_pkg::OP_STEP;
          position_next   = pstep;
          tick_count_next = 16'd1;
        end else begin
          tick_count_next = tick_count + 16'd1;
        end
      end
      lssfa_pkg::CMD_READ: job.op = lssfa_pkg::OP_READ;
      lssfa_pkg::CMD_WPAT: job.op = lssfa_pkg::OP_WPAT;
      lssfa_pkg::CMD_WLED: job.op = lssfa_pkg::OP_WLED;
      default: job.op = lssfa_pkg::OP_NONE;
    endcase
    job.fill_position = (position_next >= len) ?
                        lssfa_pkg::PW'(lssfa_pkg::MAX_LEDS) : position_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      position   <= '0;
    end else if (push) begin
      tick_count <= tick_count_next;
      position   <= position_next;
    end
  end

endmodule

// ===== src/lssfa_queue.sv =====
// ----------------------------------------------------------------------------
// lssfa_queue
// Short job queue between the command front and the memory back.
// ----------------------------------------------------------------------------
module lssfa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lssfa_pkg::job_t push_job,
  input  logic            pop,
  output lssfa_pkg::job_t head,
  output logic            empty,
  output logic            full
);

  lssfa_pkg::job_t             slots [lssfa_pkg::QDEPTH];
  logic [lssfa_pkg::QAW-1:0]   wr_ptr;
  logic [lssfa_pkg::QAW-1:0]   rd_ptr;
  logic [lssfa_pkg::QAW:0]     count;

  assign empty = (count == '0);
  assign full  = (count == (lssfa_pkg::QAW+1)'(lssfa_pkg::QDEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + lssfa_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lssfa_pkg::QAW'(1);
      end
      if (push && !pop) begin
        count <= count + (lssfa_pkg::QAW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (lssfa_pkg::QAW+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job popped from empty queue");
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (push == pop) |=> $stable(count))
    else $error("queue count moved without net change");

endmodule

// ===== src/lssfa_back.sv =====
// ----------------------------------------------------------------------------
// lssfa_back
// Carries out jobs on the frame and pattern memories, holds the result.
// ----------------------------------------------------------------------------
module lssfa_back (
  input  logic            clk,
  input  logic            rst,
  input  lssfa_pkg::cfg_t cfg,
  input  lssfa_pkg::job_t head,
  input  logic            empty,
  output logic            pop,
  lssfa_out_if.source     out_ch
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RDWAIT = 4'd1;
  localparam logic [3:0] ST_PAT    = 4'd2;
  localparam logic [3:0] ST_PCAP   = 4'd3;
  localparam logic [3:0] ST_SHINIT = 4'd4;
  localparam logic [3:0] ST_SHCAP  = 4'd5;
  localparam logic [3:0] ST_SHRD   = 4'd6;
  localparam logic [3:0] ST_SHWR   = 4'd7;
  localparam logic [3:0] ST_PUT    = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  localparam int AW = lssfa_pkg::AW;
  localparam int CW = lssfa_pkg::CW;

  logic [3:0]     state;
  lssfa_pkg::job_t job;
  logic           phase_cur;
  logic [AW-1:0]  dst;
  logic [CW-1:0]  fill;
  logic [CW-1:0]  pat;
  logic [CW-1:0]  color;

  // frame memory, single port, with per-entry valid bits for reset to zero
  logic [CW-1:0]       fmem [lssfa_pkg::MAX_LEDS];
  logic [lssfa_pkg::MAX_LEDS-1:0] fvalid;
  logic [CW-1:0]       frd;
  logic                f_re;
  logic                f_we;
  logic [AW-1:0]       f_addr;
  logic [CW-1:0]       f_wd;

  // pattern memory
  logic [CW-1:0]       pmem [lssfa_pkg::MAX_LEDS];
  logic [CW-1:0]       prd;
  logic                p_re;
  logic                p_we;
  logic [AW-1:0]       p_addr;

  logic [AW-1:0]       lo;
  logic [AW-1:0]       hi;
  logic [AW-1:0]       last;
  logic [AW-1:0]       src;
  logic [AW-1:0]       first;
  logic [AW-1:0]       stop;
  logic [lssfa_pkg::PW-1:0] inj_idx;
  logic                load_out;

  always_comb begin
    last = AW'(job.len - lssfa_pkg::PW'(1));
    // placed part and current segment sit on opposite sides of the position
    if (phase_cur == cfg.direction_up) begin
      lo = '0;
      hi = job.pos;
    end else begin
      lo = job.pos;
      hi = last;
    end
    first   = cfg.direction_up ? hi : lo;
    stop    = cfg.direction_up ? lo : hi;
    src     = cfg.direction_up ? dst - AW'(1) : dst + AW'(1);
    inj_idx = job.len - {1'b0, job.pos} - lssfa_pkg::PW'(1);
  end

  always_comb begin
    pop    = 1'b0;
    f_re   = 1'b0;
    f_we   = 1'b0;
    f_addr = dst;
    f_wd   = fill;
    p_re   = 1'b0;
    p_we   = 1'b0;
    p_addr = head.addr;
    case (state)
      ST_IDLE: begin
        pop    = !empty;
        f_addr = head.addr;
        f_wd   = head.color;
        if (!empty) begin
          f_re = (head.op == lssfa_pkg::OP_READ);
          f_we = (head.op == lssfa_pkg::OP_WLED);
          p_we = (head.op == lssfa_pkg::OP_WPAT);
        end
      end
      ST_PAT: begin
        p_re   = 1'b1;
        p_addr = cfg.move_current ? inj_idx[AW-1:0] : job.pos;
      end
      ST_SHINIT: begin
        f_re   = !phase_cur;
        f_addr = first;
      end
      ST_SHRD: begin
        if (dst == stop) begin
          f_we = 1'b1;
        end else begin
          f_re   = 1'b1;
          f_addr = src;
        end
      end
      ST_SHWR: begin
        f_we = 1'b1;
        f_wd = frd;
      end
      ST_PUT: begin
        f_we   = 1'b1;
        f_addr = job.pos;
        f_wd   = pat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fmem[f_addr] <= f_wd;
    end
    if (f_re) begin
      frd <= fvalid[f_addr] ? fmem[f_addr] : '0;
    end
    if (p_we) begin
      pmem[p_addr] <= head.color;
    end
    if (p_re) begin
      prd <= pmem[p_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= '0;
    end else if (f_we) begin
      fvalid[f_addr] <= 1'b1;
    end
  end

  assign load_out = (state == ST_DONE) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase_cur <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            job   <= head;
            color <= '0;
            if (head.op == lssfa_pkg::OP_READ) begin
              state <= ST_RDWAIT;
            end else if (head.op == lssfa_pkg::OP_STEP) begin
              state <= ST_PAT;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_RDWAIT: begin
          color <= frd;
          state <= ST_DONE;
        end
        ST_PAT: state <= ST_PCAP;
        ST_PCAP: begin
          pat <= prd;
          if (cfg.move_placed) begin
            phase_cur <= 1'b0;
            state     <= ST_SHINIT;
          end else if (cfg.move_current) begin
            phase_cur <= 1'b1;
            state     <= ST_SHINIT;
          end else begin
            state <= ST_PUT;
          end
        end
        ST_SHINIT: begin
          dst <= first;
          if (phase_cur) begin
            fill  <= pat;
            state <= ST_SHRD;
          end else begin
            state <= ST_SHCAP;
          end
        end
        ST_SHCAP: begin
          // rotation: the entry pushed off the far end comes back in
          fill  <= frd;
          state <= ST_SHRD;
        end
        ST_SHRD: begin
          if (dst == stop) begin
            if (!phase_cur && cfg.move_current) begin
              phase_cur <= 1'b1;
              state     <= ST_SHINIT;
            end else if (!phase_cur) begin
              state <= ST_PUT;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            state <= ST_SHWR;
          end
        end
        ST_SHWR: begin
          dst   <= src;
          state <= ST_SHRD;
        end
        ST_PUT: state <= ST_DONE;
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.fill_position <= job.fill_position;
      out_ch.finished      <= job.finished;
      out_ch.read_color    <= color;
    end
  end

endmodule

// ===== src/led_strip_stream_fill_animator_top.sv =====
// ----------------------------------------------------------------------------
// led_strip_stream_fill_animator_top
// Led strip fill animator: command front, job queue, memory back end.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   command, led_address, color_value
//   out_ch   out  valid/ready   fill_position, finished, read_color
//   cfg      in   cfg_we        cfg_index, cfg_data
//
// in_ch writes into the queue registers; the back end then takes each job: a read
// via RDWAIT, writes and plain ticks straight to DONE, a fill step via PAT, PCAP,
// then PUT or the shift loops, bound by the single frame port.
// the front keeps taking commands while the two-entry queue has room.
// reset is synchronous; the frame clears at once through per-led valid bits.
// a result waiting on out_ch stalls the back end, and in_ch once the queue fills.
// ----------------------------------------------------------------------------
module led_strip_stream_fill_animator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  lssfa_in_if.sink    in_ch,
  lssfa_out_if.source out_ch
);

  lssfa_pkg::cfg_t cfg;
  lssfa_pkg::job_t push_job;
  lssfa_pkg::job_t head;
  logic            push;
  logic            pop;
  logic            empty;
  logic            full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strip_length  <= 7'd64;
      cfg.step_interval <= 16'd1;
      cfg.direction_up  <= 1'b1;
      cfg.move_placed   <= 1'b0;
      cfg.move_current  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lssfa_pkg::REG_STRIP_LENGTH:  cfg.strip_length  <= cfg_data[6:0];
        lssfa_pkg::REG_STEP_INTERVAL: cfg.step_interval <= cfg_data;
        lssfa_pkg::REG_DIRECTION_UP:  cfg.direction_up  <= cfg_data[0];
        lssfa_pkg::REG_MOVE_PLACED:   cfg.move_placed   <= cfg_data[0];
        lssfa_pkg::REG_MOVE_CURRENT:  cfg.move_current  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lssfa_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (full),
    .push   (push),
    .job    (push_job)
  );

  lssfa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  lssfa_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the led strip fill animator. Items go in through a queue-fed
// driver. A predictor follows the frame, the pattern table, the tick counter
// and the position, and the monitor checks each result against it. The run
// goes through several register settings and idling phases, including a
// long output stall and a sender pause.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  led_address;
    logic [23:0] color_value;
  } cmd_item_t;

  typedef struct packed {
    logic [6:0]  fill_position;
    logic        finished;
    logic [23:0] read_color;
  } anim_result_t;

  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID   = 3'd6;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  lssfa_in_if  in_if ();
  lssfa_out_if out_if ();

  led_strip_stream_fill_animator_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_if.sink),
    .out_ch    (out_if.source)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predictor state
  logic [23:0]  frame_q [lssfa_pkg::MAX_LEDS];
  logic [23:0]  pattern_q [lssfa_pkg::MAX_LEDS];
  logic [15:0]  tick_cnt;
  int           fill_pos;
  logic [6:0]   r_strip_length;
  logic [15:0]  r_step_interval;
  logic         r_direction_up;
  logic         r_move_placed;
  logic         r_move_current;

  cmd_item_t    pending_items[$];
  anim_result_t expected_results[$];
  int           mismatch_count;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_go;
  int           hold_seen;
  int           hold_left;

  function automatic int strip_len();
    int n;
    if (r_strip_length == 7'd0) begin
      n = 1;
    end else if (r_strip_length > 7'(lssfa_pkg::MAX_LEDS)) begin
      n = lssfa_pkg::MAX_LEDS;
    end else begin
      n = int'(r_strip_length);
    end
    return n;
  endfunction

  function automatic int home_pos();
    return r_direction_up ? 0 : strip_len() - 1;
  endfunction

  function automatic void swap_frame(input int a, input int b);
    logic [23:0] t;
    t = frame_q[a];
    frame_q[a] = frame_q[b];
    frame_q[b] = t;
  endfunction

  function automatic void take_step(input int len);
    int          k;
    int          pidx;
    logic [23:0] inj;
    pidx = len - fill_pos - 1;
    inj = (pidx >= 0 && pidx < lssfa_pkg::MAX_LEDS) ? pattern_q[pidx] : 24'd0;
    if (r_direction_up) begin
      if (r_move_placed) begin
        for (k = len - 1; k > fill_pos; k--) swap_frame(k, k - 1);
      end
      if (r_move_current) begin
        for (k = fill_pos; k > 0; k--) swap_frame(k, k - 1);
        frame_q[0] = inj;
      end else begin
        frame_q[fill_pos] = pattern_q[fill_pos];
      end
      fill_pos++;
      if (fill_pos >= len) fill_pos = len;
    end else begin
      if (r_move_placed) begin
        for (k = 0; k < fill_pos; k++) swap_frame(k, k + 1);
      end
      if (r_move_current) begin
        for (k = fill_pos; k < len - 1; k++) swap_frame(k, k + 1);
        frame_q[len - 1] = inj;
      end else begin
        frame_q[fill_pos] = pattern_q[fill_pos];
      end
      fill_pos--;
      if (fill_pos < 0) fill_pos = len;
    end
  endfunction

  function automatic anim_result_t animate(input cmd_item_t it);
    anim_result_t r;
    int           len;
    len = strip_len();
    r = '0;
    case (it.command)
      lssfa_pkg::CMD_RESTART: begin
        tick_cnt = '0;
        fill_pos = home_pos();
      end
      lssfa_pkg::CMD_TICK: begin
        if (tick_cnt == 16'd0) fill_pos = home_pos();
        if (fill_pos >= len || fill_pos < 0) begin
          r.finished = 1'b1;
        end else begin
          if (tick_cnt >= r_step_interval) begin
            tick_cnt = '0;
            take_step(len);
          end
          tick_cnt = tick_cnt + 16'd1;
        end
      end
      lssfa_pkg::CMD_READ: r.read_color = frame_q[it.led_address];
      lssfa_pkg::CMD_WPAT: pattern_q[it.led_address] = it.color_value;
      lssfa_pkg::CMD_WLED: frame_q[it.led_address] = it.color_value;
      default: ;
    endcase
    r.fill_position = (fill_pos >= len || fill_pos < 0) ?
                      7'(lssfa_pkg::MAX_LEDS) : 7'(fill_pos);
    return r;
  endfunction

  // driver: offers the next pending item, predicts on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(animate('{in_if.command, in_if.led_address,
                                             in_if.color_value}));
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cmd_item_t it;
          it = pending_items.pop_front();
          in_if.valid       <= 1'b1;
          in_if.command     <= it.command;
          in_if.led_address <= it.led_address;
          in_if.color_value <= it.color_value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long output stall, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go != hold_seen) begin
      hold_left <= 400;
      hold_seen <= hold_go;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: pos %0d fin %0d col %06h",
                     out_if.fill_position, out_if.finished, out_if.read_color);
        end else begin
          anim_result_t e;
          e = expected_results.pop_front();
          if (e.fill_position !== out_if.fill_position ||
              e.finished !== out_if.finished ||
              e.read_color !== out_if.read_color) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected pos %0d fin %0d col %06h, %s %0d %s %0d %s %06h",
                       e.fill_position, e.finished, e.read_color,
                       "got pos", out_if.fill_position, "fin", out_if.finished,
                       "col", out_if.read_color);
          end
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic push_item(input logic [2:0] cmd, input logic [5:0] a, input logic [23:0] c);
    pending_items.push_back('{cmd, a, c});
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      lssfa_pkg::REG_STRIP_LENGTH:  r_strip_length  = d[6:0];
      lssfa_pkg::REG_STEP_INTERVAL: r_step_interval = d;
      lssfa_pkg::REG_DIRECTION_UP:  r_direction_up  = d[0];
      lssfa_pkg::REG_MOVE_PLACED:   r_move_placed   = d[0];
      lssfa_pkg::REG_MOVE_CURRENT:  r_move_current  = d[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(input int n);
    int          k;
    int          roll;
    logic [23:0] c;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      c = ($urandom_range(0, 9) == 0) ? {24{roll[0]}} : 24'($urandom);
      if (roll < 60) push_item(lssfa_pkg::CMD_TICK, 6'($urandom), c);
      else if (roll < 66) push_item(lssfa_pkg::CMD_RESTART, 6'($urandom), c);
      else if (roll < 80) push_item(lssfa_pkg::CMD_READ, 6'($urandom), c);
      else if (roll < 88) push_item(lssfa_pkg::CMD_WLED, 6'($urandom), c);
      else if (roll < 95) push_item(lssfa_pkg::CMD_WPAT, 6'($urandom), c);
      else push_item(3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)), 6'($urandom), c);
    end
  endtask

  initial begin
    int k;
    int ph;
    int settings [8][5];
    settings = '{
      '{64, 1, 1, 0, 0}, '{64, 0, 1, 1, 1}, '{1, 65535, 0, 0, 1}, '{0, 3, 0, 1, 0},
      '{127, 0, 0, 1, 1}, '{7, 2, 1, 1, 0}, '{12, 0, 0, 0, 1}, '{5, 1, 1, 0, 1}};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.command = lssfa_pkg::CMD_RESTART;
    in_if.led_address = '0;
    in_if.color_value = '0;
    out_if.ready = 1'b0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go = 0;
    for (k = 0; k < lssfa_pkg::MAX_LEDS; k++) begin
      frame_q[k] = '0;
      pattern_q[k] = '0;
    end
    tick_cnt = '0;
    fill_pos = 0;
    r_strip_length = 7'd64;
    r_step_interval = 16'd1;
    r_direction_up = 1'b1;
    r_move_placed = 1'b0;
    r_move_current = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // fill the whole pattern table so no step reads an unwritten entry
    for (k = 0; k < lssfa_pkg::MAX_LEDS; k++)
      push_item(lssfa_pkg::CMD_WPAT, 6'(k),
                (k == 0) ? 24'h000000 : (k == 63) ? 24'hFFFFFF : 24'($urandom));
    // directed: field extremes, the remaining commands, unknown codes, first fill steps
    push_item(lssfa_pkg::CMD_READ, 6'd0, 24'hFFFFFF);
    push_item(lssfa_pkg::CMD_READ, 6'd63, 24'h000000);
    push_item(lssfa_pkg::CMD_WLED, 6'd63, 24'hFFFFFF);
    push_item(lssfa_pkg::CMD_WLED, 6'd0, 24'h000000);
    push_item(lssfa_pkg::CMD_READ, 6'd63, 24'h0);
    push_item(CMD_UNUSED_FIRST, 6'd1, 24'h1);
    push_item(CMD_UNUSED_MID, 6'd2, 24'h2);
    push_item(CMD_UNUSED_LAST, 6'd3, 24'h3);
    push_item(lssfa_pkg::CMD_RESTART, 6'd0, 24'h0);
    for (k = 0; k < 8; k++) push_item(lssfa_pkg::CMD_TICK, 6'd0, 24'h0);
    push_item(lssfa_pkg::CMD_READ, 6'd1, 24'h0);
    push_item(lssfa_pkg::CMD_READ, 6'd2, 24'h0);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      write_reg(lssfa_pkg::REG_STRIP_LENGTH, 16'(settings[ph][0]));
      write_reg(lssfa_pkg::REG_STEP_INTERVAL, 16'(settings[ph][1]));
      write_reg(lssfa_pkg::REG_DIRECTION_UP, 16'(settings[ph][2]));
      write_reg(lssfa_pkg::REG_MOVE_PLACED, 16'(settings[ph][3]));
      write_reg(lssfa_pkg::REG_MOVE_CURRENT, 16'(settings[ph][4]));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      push_item(lssfa_pkg::CMD_RESTART, 6'($urandom), 24'($urandom));
      if (ph == 1) hold_go = hold_go + 1;
      random_items(30);
      // sender pauses until everything has come back
      while (pending_items.size() != 0 || in_if.valid || expected_results.size() != 0)
        @(posedge clk);
      random_items(20);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
